// ----- hdl/rcd_pkg.sv -----
// Shared types, constants and channel-widening functions for the RGB565 crop/decimate unit.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rcd_pkg;

	// Input raster geometry
	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 240;

	localparam int COL_W = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
	localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

	// Configuration register width and the width used for window compares
	localparam int CFG_W  = 9;
	localparam int CMP_W  = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Last kept row: largest even row in the frame
	localparam int LAST_ROW = ((FRAME_HEIGHT - 1) / 2) * 2;

	// Reset values of the column window
	localparam logic [CFG_W-1:0] FIRST_COLUMN_RST = CFG_W'(40);
	localparam logic [CFG_W-1:0] END_COLUMN_RST   = CFG_W'(280);

	localparam int PIXEL_W = 16;
	localparam int CHAN_W  = 8;

	// Register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_FIRST_COLUMN = 1'b0,
		REG_END_COLUMN   = 1'b1
	} rcd_reg_t;

	// Column window as seen by the position tracker
	typedef struct packed {
		logic [CFG_W-1:0] first_column;
		logic [CFG_W-1:0] end_column;
	} rcd_cfg_t;

	// Kept pixel on its way to the converter
	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               last;
	} rcd_item_t;

	// Widen a 5-bit channel: (v*527+23)>>6
	function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] v);
		logic [14:0] t;
		t = 15'(v) * 15'd527 + 15'd23;
		return t[13:6];
	endfunction

	// Widen a 6-bit channel: (v*259+33)>>6
	function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] v);
		logic [14:0] t;
		t = 15'(v) * 15'd259 + 15'd33;
		return t[13:6];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/rcd_cfg.sv -----
// APB-style register file holding the column window (first_column, end_column).
// Depends on rcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcd_cfg import rcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output rcd_cfg_t               cfg
);

	logic [CFG_W-1:0] first_column_q;
	logic [CFG_W-1:0] end_column_q;
	rcd_reg_t         sel;
	logic             wr_en;

	assign sel    = rcd_reg_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_column_q <= FIRST_COLUMN_RST;
			end_column_q   <= END_COLUMN_RST;
		end else if (wr_en) begin
			case (sel)
				REG_FIRST_COLUMN: first_column_q <= pwdata[CFG_W-1:0];
				REG_END_COLUMN:   end_column_q   <= pwdata[CFG_W-1:0];
				default:          ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (sel)
			REG_FIRST_COLUMN: prdata = DATA_W'(first_column_q);
			REG_END_COLUMN:   prdata = DATA_W'(end_column_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.first_column = first_column_q;
	assign cfg.end_column   = end_column_q;

endmodule

`default_nettype wire

// ----- hdl/rcd_track.sv -----
// Column/row tracker and keep decision; holds kept pixels in the stage-1 register.
// Depends on rcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcd_track import rcd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rcd_cfg_t           cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [PIXEL_W-1:0] pixel,
	input  wire logic               frame_start,
	output logic                    out_valid,
	output rcd_item_t               out_item,
	input  wire logic               out_ready
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] cur_row;
	logic [CMP_W-1:0] col_x;
	logic [CMP_W-1:0] first_x;
	logic [CMP_W-1:0] end_x;
	logic [CMP_W-1:0] limit;
	logic [CMP_W-1:0] last_col;
	logic             keep;
	logic             last;
	logic             accept;
	logic             valid_s1;
	rcd_item_t        item_s1;

	// Position of this pixel; a frame start restarts at the origin
	assign cur_col = frame_start ? '0 : col_q;
	assign cur_row = frame_start ? '0 : row_q;

	// Window test and last-pixel test
	always_comb begin
		col_x    = CMP_W'(cur_col);
		first_x  = CMP_W'(cfg.first_column);
		end_x    = CMP_W'(cfg.end_column);
		limit    = (end_x < CMP_W'(FRAME_WIDTH)) ? end_x : CMP_W'(FRAME_WIDTH);
		last_col = (limit - CMP_W'(1)) & ~CMP_W'(1);
		keep     = !cur_col[0] && !cur_row[0] && (col_x >= first_x) && (col_x < end_x);
		last     = (col_x == last_col) && (cur_row == ROW_W'(LAST_ROW));
	end

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// Advance the raster position on every transfer, wrapping at line and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (cur_col == COL_W'(FRAME_WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (cur_row == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : cur_row + ROW_W'(1);
			end else begin
				col_q <= cur_col + COL_W'(1);
				row_q <= cur_row;
			end
		end
	end

	// Stage-1 valid: load on a kept pixel, drop once taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage-1 payload
	always_ff @(posedge clk) begin
		if (accept && keep) begin
			item_s1.pixel <= pixel;
			item_s1.last  <= last;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < FRAME_WIDTH)
		else $error("column counter out of frame");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) < FRAME_HEIGHT)
		else $error("row counter out of frame");

	a_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> col_q == COL_W'(1) && row_q == '0)
		else $error("frame start did not restart position");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(item_s1))
		else $error("stage-1 item lost while stalled");

endmodule

`default_nettype wire

// ----- hdl/rcd_convert.sv -----
// RGB565 to RGB888 widening into the output register.
// Depends on rcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcd_convert import rcd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rcd_item_t           in_item,
	output logic                     out_valid,
	output logic [3*CHAN_W-1:0]      out_rgb,
	output logic                     out_last,
	input  wire logic                out_ready
);

	logic                valid_q;
	logic [CHAN_W-1:0]   red_q;
	logic [CHAN_W-1:0]   green_q;
	logic [CHAN_W-1:0]   blue_q;
	logic                last_q;
	logic                load;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;

	// Output valid: set on load, clear once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Widen each channel as it enters the output register
	always_ff @(posedge clk) begin
		if (load) begin
			red_q   <= widen5(in_item.pixel[15:11]);
			green_q <= widen6(in_item.pixel[10:5]);
			blue_q  <= widen5(in_item.pixel[4:0]);
			last_q  <= in_item.last;
		end
	end

	assign out_valid = valid_q;
	assign out_rgb   = {blue_q, green_q, red_q};
	assign out_last  = last_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- hdl/rgb565_crop_decimate_to_rgb888_unit.sv -----
// Top level of the RGB565 crop/decimate to RGB888 unit.
// Depends on rcd_pkg, rcd_cfg, rcd_track and rcd_convert.
`timescale 1ns / 1ps
`default_nettype none

// Takes one RGB565 pixel per cycle in raster order (s_tuser marks the first pixel of a
// frame) and passes on only pixels on even rows and even columns inside the window
// first_column <= column < end_column (40..279 after reset, giving 120x120 from 320x240).
// Each kept pixel leaves as 8-bit red, green and blue, with m_tlast on the last pixel of
// the output frame. Throughput is one input pixel per cycle whenever the output side is
// not stalled; a kept pixel passes through the tracker register, then the output
// register. Dropped pixels produce nothing. Write the window registers only while no
// pixel is in flight.
module rgb565_crop_decimate_to_rgb888_unit import rcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// Pixel input
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,   // [15:0] pixel
	input  wire logic              s_tuser,   // [0] frame_start
	// Pixel output
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [23:0]            m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	output logic                   m_tlast    // frame_last
);

	rcd_cfg_t  cfg;
	rcd_item_t item;
	logic      item_valid;
	logic      item_ready;

	rcd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcd_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pixel       (s_tdata),
		.frame_start (s_tuser),
		.out_valid   (item_valid),
		.out_item    (item),
		.out_ready   (item_ready)
	);

	rcd_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_item   (item),
		.out_valid (m_tvalid),
		.out_rgb   (m_tdata),
		.out_last  (m_tlast),
		.out_ready (m_tready)
	);

endmodule

`default_nettype wire
